// File: hw/rtl/slfp_pkg.sv
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared types and constants for the sync/length frame parser.
// ----------------------------------------------------------------------------
package slfp_pkg;

    localparam logic [7:0] SYNC_A   = 8'hAA;
    localparam logic [7:0] SYNC_B   = 8'hBB;
    localparam logic [7:0] IND_HEAD = 8'h86;
    localparam logic [1:0] CODE_FULL    = 2'd1;
    localparam logic [1:0] CODE_TIMEOUT = 2'd2;
    localparam int unsigned HEADER_LEN = 5;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    // Command from front to back through the queue.
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CHECK,
        ST_RD0,
        ST_RD1,
        ST_HDR,
        ST_SKIP,
        ST_SCAN,
        ST_SCAN_RD,
        ST_EMIT_RD,
        ST_EMIT,
        ST_IND,
        ST_TICK
    } t_state;

endpackage

// File: hw/rtl/slfp_front.sv
// ----------------------------------------------------------------------------
// slfp_front
// Input stage plus a two-entry queue of classified commands.
// ----------------------------------------------------------------------------
module slfp_front
    import slfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [8:0] i_data,
    output logic       o_cmd_valid,
    input  logic       i_cmd_pop,
    output t_cmd       o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{op: t_op'(i_data[0]), data: i_data[8:1]};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop of empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_cmd_pop) |=> (r_cnt == 2'd2)) else $error("queue lost entry");

endmodule

// File: hw/rtl/slfp_back.sv
// ----------------------------------------------------------------------------
// slfp_back
// Buffer, parse sequencer and timeout timer; emits result bytes.
// ----------------------------------------------------------------------------
module slfp_back
    import slfp_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    input  logic [15:0] i_timeout_ticks,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [15:0]   r_tcnt, n_tcnt;
    logic          r_trun, n_trun;
    t_state        r_st, n_st;
    logic [7:0]    r_b0, n_b0;       // peek(0) / header bytes
    logic [7:0]    r_len_hi, n_len_hi;
    logic [16:0]   r_rem, n_rem;     // bytes still to emit or scan index
    logic [1:0]    r_icode, n_icode;
    logic [1:0]    r_iidx, n_iidx;
    logic [2:0]    r_hidx, n_hidx;
    logic [7:0]    r_prev, n_prev;
    logic          r_ovalid, n_ovalid;
    logic [11:0]   r_odata, n_odata;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] n_raddr, r_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW:0]   w_wsum;
    logic          w_out_free;
    logic [16:0]   w_total;

    assign w_out_free = !r_ovalid || i_ready;
    assign w_wsum     = {1'b0, r_rp} + (AW+1)'(r_cnt);
    // pointer plus count stays below twice the depth: one subtract wraps it
    assign w_waddr    = (w_wsum >= (AW+1)'(BUFFER_DEPTH)) ?
                        AW'(w_wsum - (AW+1)'(BUFFER_DEPTH)) : AW'(w_wsum);
    assign w_we       = (r_st == ST_WRITE);
    assign w_total    = {r_len_hi, r_b0} + 17'(HEADER_LEN);
    assign w_raddr    = r_raddr;

    // offsets never exceed the depth, so a single compare and subtract wraps
    function automatic logic [AW-1:0] f_add(input logic [AW-1:0] a, input logic [16:0] k);
        logic [17:0] s;
        s = 18'(a) + {1'b0, k};
        if (s >= 18'(BUFFER_DEPTH)) s = s - 18'(BUFFER_DEPTH);
        return AW'(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= i_cmd.data;
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_tcnt   <= '0;
            r_trun   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_rp     <= n_rp;
            r_cnt    <= n_cnt;
            r_tcnt   <= n_tcnt;
            r_trun   <= n_trun;
            r_ovalid <= n_ovalid;
        end
        r_b0     <= n_b0;
        r_len_hi <= n_len_hi;
        r_rem    <= n_rem;
        r_icode  <= n_icode;
        r_iidx   <= n_iidx;
        r_hidx   <= n_hidx;
        r_prev   <= n_prev;
        r_odata  <= n_odata;
        r_raddr  <= n_raddr;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    always_comb begin
        n_st     = r_st;
        n_rp     = r_rp;
        n_cnt    = r_cnt;
        n_tcnt   = r_tcnt;
        n_trun   = r_trun;
        n_b0     = r_b0;
        n_len_hi = r_len_hi;
        n_rem    = r_rem;
        n_icode  = r_icode;
        n_iidx   = r_iidx;
        n_hidx   = r_hidx;
        n_prev   = r_prev;
        n_raddr  = r_raddr;
        n_ovalid = r_ovalid && !i_ready;
        n_odata  = r_odata;
        o_cmd_pop = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_st = (i_cmd.op == OP_BYTE) ? ST_WRITE : ST_TICK;
                end
            end
            ST_WRITE: begin
                o_cmd_pop = 1'b1;
                n_tcnt = '0;
                n_trun = 1'b1;
                if (r_cnt == CW'(BUFFER_DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_rp    = '0;
                    n_icode = CODE_FULL;
                    n_iidx  = 2'd0;
                    n_st    = ST_IND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_st  = ST_CHECK;
                end
            end
            ST_TICK: begin
                o_cmd_pop = 1'b1;
                n_st = ST_IDLE;
                if (r_trun) begin
                    n_tcnt = r_tcnt + 1'b1;
                    if (n_tcnt >= i_timeout_ticks || n_tcnt == '0) begin
                        n_trun = 1'b0;
                        n_tcnt = '0;
                        if (r_cnt != '0) begin
                            n_cnt   = '0;
                            n_rp    = '0;
                            n_icode = CODE_TIMEOUT;
                            n_iidx  = 2'd0;
                            n_st    = ST_IND;
                        end
                    end
                end
            end
            ST_IND: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    case (r_iidx)
                        2'd0:    n_odata = {1'b0, r_icode, 1'b1, IND_HEAD};
                        2'd1:    n_odata = {1'b0, r_icode, 1'b1, 8'h00};
                        2'd2:    n_odata = {1'b0, r_icode, 1'b1, 8'h01};
                        default: n_odata = {1'b1, r_icode, 1'b1, 6'd0, r_icode};
                    endcase
                    n_iidx = r_iidx + 1'b1;
                    if (r_iidx == 2'd3) n_st = ST_IDLE;
                end
            end
            // top of parse loop: need header worth of bytes
            ST_CHECK: begin
                if (r_cnt < CW'(HEADER_LEN)) begin
                    n_st = ST_IDLE;
                end else begin
                    n_raddr = r_rp;
                    n_st    = ST_RD0;
                end
            end
            ST_RD0: begin
                // read issued; next cycle data of peek(0)
                n_raddr = f_add(r_rp, 17'd1);
                n_st    = ST_RD1;
            end
            ST_RD1: begin
                n_b0  = r_rdata;
                n_st  = ST_SKIP;
                n_raddr = f_add(r_rp, 17'd2);
            end
            // peek(1) available in r_rdata; drop until sync or lone trailing AA
            ST_SKIP: begin
                if (r_b0 == SYNC_A && (r_cnt == CW'(1) || r_rdata == SYNC_B)) begin
                    if (r_cnt < CW'(HEADER_LEN)) begin
                        n_st = ST_IDLE;
                    end else begin
                        n_hidx  = 3'd2;
                        n_raddr = f_add(r_rp, 17'd3);
                        n_st    = ST_HDR;
                    end
                end else begin
                    n_rp  = f_add(r_rp, 17'd1);
                    n_cnt = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_rp   = '0;
                        n_trun = 1'b0;
                        n_st   = ST_IDLE;
                    end else begin
                        n_b0    = r_rdata;
                        n_raddr = f_add(r_rp, 17'd3);
                        n_st    = ST_SKIP;
                        n_hidx  = 3'd0;
                    end
                end
            end
            // r_rdata holds peek(hidx); collect length bytes 3 and 4
            ST_HDR: begin
                n_hidx  = r_hidx + 1'b1;
                n_raddr = f_add(r_rp, 17'd4);
                if (r_hidx == 3'd3) n_len_hi = r_rdata;
                if (r_hidx == 3'd4) begin
                    n_b0 = r_rdata;
                    n_st = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ({1'b0, 16'(r_cnt)} >= w_total) begin
                    n_rem   = w_total - 17'd2;
                    n_rp    = f_add(r_rp, 17'd2);
                    n_cnt   = r_cnt - CW'(2);
                    n_raddr = f_add(r_rp, 17'd2);
                    n_st    = ST_EMIT_RD;
                end else begin
                    n_rem   = 17'd0;
                    n_raddr = f_add(r_rp, 17'd2);
                    n_st    = ST_SCAN_RD;
                    n_hidx  = 3'd0;
                end
            end
            // scan for sync at offset i+2; r_rem = i, r_hidx flags prev valid
            ST_SCAN_RD: begin
                if (r_hidx == 3'd0) begin
                    n_hidx  = 3'd1;
                    n_raddr = f_add(r_rp, 17'd3);
                end else begin
                    if (r_hidx == 3'd2 && r_prev == SYNC_A && r_rdata == SYNC_B) begin
                        n_rp  = f_add(r_rp, 17'd2);
                        n_cnt = r_cnt - CW'(2);
                        n_st  = ST_CHECK;
                    end else if (r_hidx == 3'd2 && r_rem + 17'd4 >= 17'(r_cnt)) begin
                        n_st = ST_IDLE;
                    end else begin
                        if (r_hidx == 3'd2) n_rem = r_rem + 1'b1;
                        n_hidx  = 3'd2;
                        n_prev  = r_rdata;
                        // read address runs one byte ahead of r_rdata
                        n_raddr = f_add(r_rp,
                                        (r_hidx == 3'd2 ? r_rem + 17'd1 : 17'd0) + 17'd4);
                    end
                end
            end
            ST_EMIT_RD: begin
                n_st = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {(r_rem == 17'd1), 2'd0, 1'b0, r_rdata};
                    n_rp     = f_add(r_rp, 17'd1);
                    n_cnt    = r_cnt - 1'b1;
                    n_rem    = r_rem - 1'b1;
                    n_raddr  = f_add(r_rp, 17'd1);
                    n_st     = ST_EMIT_RD;
                    if (r_rem == 17'd1) begin
                        if (r_cnt == CW'(1)) begin
                            n_rp   = '0;
                            n_trun = 1'b0;
                            n_st   = ST_IDLE;
                        end else begin
                            n_st = ST_CHECK;
                        end
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(BUFFER_DEPTH - 1)) else $error("byte count overflow");
    a_emit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EMIT) |-> (r_rem != 17'd0)) else $error("emit with nothing left");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_odata))) else $error("output lost");
    a_pop_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_st == ST_WRITE || r_st == ST_TICK)) else $error("bad pop");

endmodule

// File: hw/rtl/sync_length_frame_parser.sv
// ----------------------------------------------------------------------------
// sync_length_frame_parser
// Buffers received bytes and ticks, finds AA BB framed packets, emits them.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser[0] = operation (0 byte, 1 tick), tdata[7:0] =
// rx_byte. Output stream m_axis: tdata = out_byte, tuser[0] = is_indication,
// tuser[2:1] = status_code, tlast = last of a frame or indication.
// Config: i_cfg_we writes timeout_ticks from i_cfg_wdata (reset 2000).
// A two-entry queue decouples the input from the parse sequencer, so input
// is taken while results wait. Per byte the sequencer writes the buffer
// and reads the header, then scans or drops bytes and emits each result
// byte through the single buffer read port. A tick passes through the tick
// state, and through the indication state when an indication goes out.
// The output register holds a result while tready is low; the sequencer
// then waits, and the queue fills and drops s_axis_tready.
// Reset clears buffer count, pointers, timer and queue; timeout restores
// to 2000. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sync_length_frame_parser
    import slfp_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]  m_axis_tuser,   // [0] is_indication, [2:1] status_code
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic [15:0] r_timeout;
    logic        w_cmd_valid, w_cmd_pop;
    t_cmd        w_cmd;
    logic [11:0] w_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd2000;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    slfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      ({s_axis_tdata, s_axis_tuser}),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    slfp_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .i_cmd           (w_cmd),
        .o_cmd_pop       (w_cmd_pop),
        .i_timeout_ticks (r_timeout),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_data          (w_odata)
    );

    assign m_axis_tdata = w_odata[7:0];
    assign m_axis_tuser = w_odata[10:8];
    assign m_axis_tlast = w_odata[11];

endmodule

// File: test/tb_sync_length_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_sync_length_frame_parser
// Self-checking bench: bytes and ticks go in over the input stream, and every
// output transfer is checked against an in-bench model of the frame parser.
// ----------------------------------------------------------------------------
module tb_sync_length_frame_parser;
    import slfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 64;
    localparam int SETTLE    = 4 * DEPTH + 40;
    localparam int MAX_CYCLE = 1000000;

    typedef struct {
        logic [7:0] data;
        logic       ind;
        logic [1:0] code;
        logic       last;
    } t_outb;

    typedef struct {
        t_op        op;
        logic [7:0] data;
        logic [1:0] ind_code;   // nonzero: this row ends in an indication of that cause
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic [0:0]  s_axis_tuser;   // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic [2:0]  m_axis_tuser;   // [0] is_indication, [2:1] status_code
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    sync_length_frame_parser #(.BUFFER_DEPTH(DEPTH)) uut (.*);

    // parser state mirror
    logic [7:0] fifo_mem [DEPTH];
    int         rd_ptr;
    int         fill;
    int         tick_cnt;
    bit         timer_on;
    int         timeout_val;

    t_outb      pending_q [$];
    int         errors;
    int         cycles;
    int         snd_idle;
    int         rcv_idle;

    task automatic report(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic logic [7:0] peek(input int k);
        return fifo_mem[(rd_ptr + k) % DEPTH];
    endfunction

    function automatic void drop_one();
        if (fill > 0) begin
            rd_ptr = (rd_ptr + 1) % DEPTH;
            fill--;
        end
    endfunction

    function automatic void flush_all();
        fill   = 0;
        rd_ptr = 0;
    endfunction

    function automatic void push_out(input logic [7:0] b, input logic ind,
                                     input logic [1:0] code, input logic lst);
        t_outb e;
        e.data = b;
        e.ind  = ind;
        e.code = code;
        e.last = lst;
        pending_q.push_back(e);
    endfunction

    function automatic void push_indication(input logic [1:0] code);
        push_out(IND_HEAD, 1'b1, code, 1'b0);
        push_out(8'h00, 1'b1, code, 1'b0);
        push_out(8'h01, 1'b1, code, 1'b0);
        push_out({6'd0, code}, 1'b1, code, 1'b1);
    endfunction

    // returns 1 when the pass leaves the buffer empty
    function automatic bit parse_frames();
        int  len;
        int  total;
        bit  found;
        forever begin
            if (fill < HEADER_LEN)
                return 0;
            if (!(peek(0) == SYNC_A && peek(1) == SYNC_B)) begin
                while (fill > 0) begin
                    if (peek(0) == SYNC_A && (fill == 1 || peek(1) == SYNC_B))
                        break;
                    drop_one();
                end
            end
            if (fill == 0) begin
                flush_all();
                return 1;
            end
            if (fill < HEADER_LEN)
                return 0;
            len   = int'({peek(3), peek(4)});
            total = len + HEADER_LEN;
            if (fill >= total) begin
                drop_one();
                drop_one();
                for (int i = 0; i < total - 2; i++) begin
                    push_out(peek(0), 1'b0, 2'd0, i == total - 3);
                    drop_one();
                end
                if (fill == 0) begin
                    flush_all();
                    return 1;
                end
                continue;
            end
            found = 0;
            for (int i = 0; i + 3 < fill; i++) begin
                if (peek(i + 2) == SYNC_A && peek(i + 3) == SYNC_B) begin
                    found = 1;
                    break;
                end
            end
            if (!found)
                return 0;
            drop_one();
            drop_one();
        end
    endfunction

    function automatic void parser_step(input t_op op, input logic [7:0] b);
        if (op == OP_BYTE) begin
            if (fill < DEPTH) begin
                fifo_mem[(rd_ptr + fill) % DEPTH] = b;
                fill++;
            end
            tick_cnt = 0;
            timer_on = 1;
            if (fill >= DEPTH) begin
                flush_all();
                push_indication(CODE_FULL);
            end else if (parse_frames()) begin
                timer_on = 0;
            end
        end else if (timer_on) begin
            tick_cnt = (tick_cnt + 1) & 16'hFFFF;
            if (tick_cnt >= timeout_val || tick_cnt == 0) begin
                timer_on = 0;
                tick_cnt = 0;
                if (fill > 0) begin
                    flush_all();
                    push_indication(CODE_TIMEOUT);
                end
            end
        end
    endfunction

    // one input transfer; valid stays high across back-to-back transfers
    task automatic send(input t_op op, input logic [7:0] b);
        if ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < snd_idle)
                @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= op;
        do
            @(negedge i_clk);
        while (!s_axis_tready);
        @(posedge i_clk);
        parser_step(op, b);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [15:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        timeout_val = v;
    endtask

    task automatic send_rand_phase(input int count);
        int n;
        int len;
        n = 0;
        while (n < count) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    len = $urandom_range(8);
                    send(OP_BYTE, SYNC_A);
                    send(OP_BYTE, SYNC_B);
                    send(OP_BYTE, 8'($urandom_range(255)));
                    send(OP_BYTE, 8'h00);
                    send(OP_BYTE, 8'(len));
                    repeat (len) send(OP_BYTE, 8'($urandom_range(255)));
                    n += 5 + len;
                end
                6: begin
                    len = $urandom_range(1, 4);
                    repeat (len) send(OP_BYTE, 8'($urandom_range(255)));
                    n += len;
                end
                7: begin
                    len = $urandom_range(1, 5);
                    repeat (len) send(OP_TICK, 8'($urandom_range(255)));
                    n += len;
                end
                8: begin
                    // header promises more than is sent, then one more byte
                    send(OP_BYTE, SYNC_A);
                    send(OP_BYTE, SYNC_B);
                    send(OP_BYTE, 8'($urandom_range(255)));
                    send(OP_BYTE, 8'($urandom_range(255)));
                    send(OP_BYTE, 8'($urandom_range(20, 255)));
                    send(OP_BYTE, 8'($urandom_range(255)));
                    n += 6;
                end
                default: begin
                    if ($urandom_range(2) == 0) begin
                        // oversized frame: fills the buffer
                        send(OP_BYTE, SYNC_A);
                        send(OP_BYTE, SYNC_B);
                        send(OP_BYTE, 8'($urandom_range(255)));
                        send(OP_BYTE, 8'hFF);
                        send(OP_BYTE, 8'hFF);
                        repeat (DEPTH - 5) send(OP_BYTE, 8'($urandom_range(8'hA9)));
                        n += DEPTH;
                    end else begin
                        send(OP_TICK, 8'h00);
                        n++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
        if (cycles > MAX_CYCLE) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // transfer completes at the next rising edge; inputs are stable here
    always @(negedge i_clk) begin
        t_outb e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected output %02h", m_axis_tdata));
            end else begin
                e = pending_q.pop_front();
                if (m_axis_tdata !== e.data)
                    report($sformatf("byte %02h, want %02h", m_axis_tdata, e.data));
                if (m_axis_tuser[0] !== e.ind)
                    report($sformatf("indication flag %b, want %b", m_axis_tuser[0], e.ind));
                if (m_axis_tuser[2:1] !== e.code)
                    report($sformatf("code %0d, want %0d", m_axis_tuser[2:1], e.code));
                if (m_axis_tlast !== e.last)
                    report($sformatf("tlast %b, want %b", m_axis_tlast, e.last));
            end
        end
    end

    t_row rows [] = '{
        '{OP_BYTE, 8'hAA, 2'd0}, '{OP_BYTE, 8'hBB, 2'd0}, '{OP_BYTE, 8'h01, 2'd0},
        '{OP_BYTE, 8'h00, 2'd0}, '{OP_BYTE, 8'h00, 2'd0},
        // leading junk, then a frame with a two-byte payload
        '{OP_BYTE, 8'h11, 2'd0}, '{OP_BYTE, 8'hAA, 2'd0}, '{OP_BYTE, 8'hBB, 2'd0},
        '{OP_BYTE, 8'h7F, 2'd0}, '{OP_BYTE, 8'h00, 2'd0}, '{OP_BYTE, 8'h02, 2'd0},
        '{OP_BYTE, 8'hFF, 2'd0}, '{OP_BYTE, 8'h00, 2'd0},
        // incomplete frame abandoned by a later sync pair
        '{OP_BYTE, 8'hAA, 2'd0}, '{OP_BYTE, 8'hBB, 2'd0}, '{OP_BYTE, 8'h02, 2'd0},
        '{OP_BYTE, 8'h00, 2'd0}, '{OP_BYTE, 8'h05, 2'd0}, '{OP_BYTE, 8'hAA, 2'd0},
        '{OP_BYTE, 8'hBB, 2'd0}, '{OP_BYTE, 8'h03, 2'd0}, '{OP_BYTE, 8'h00, 2'd0},
        '{OP_BYTE, 8'h00, 2'd0},
        // lone trailing sync byte is kept, then flushed by the timer
        '{OP_BYTE, 8'hAA, 2'd0}, '{OP_TICK, 8'h00, 2'd0}, '{OP_TICK, 8'h00, 2'd0},
        '{OP_TICK, 8'h00, CODE_TIMEOUT}
    };

    initial begin
        t_outb tail;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        errors        = 0;
        cycles        = 0;
        rd_ptr        = 0;
        fill          = 0;
        tick_cnt      = 0;
        timer_on      = 0;
        timeout_val   = 2000;
        snd_idle      = 20;
        rcv_idle      = 76;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_timeout(16'd3);
        foreach (rows[i]) begin
            send(rows[i].op, rows[i].data);
            if (rows[i].ind_code != 2'd0) begin
                tail = pending_q.size() > 0 ? pending_q[$] :
                       t_outb'{8'h00, 1'b0, 2'd0, 1'b0};
                if (!(tail.ind && tail.last && tail.code == rows[i].ind_code))
                    report($sformatf("row %0d: no indication with code %0d", i,
                                     rows[i].ind_code));
            end
        end

        set_timeout(16'd1);
        send_rand_phase(25);
        // hold off until everything has come out
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() > 0)
            @(posedge i_clk);

        snd_idle = 76;
        rcv_idle = 20;
        set_timeout(16'd65535);
        send_rand_phase(25);

        snd_idle = 0;
        rcv_idle = 0;
        set_timeout(16'd4);
        send_rand_phase(25);

        drain();
        if (errors == 0 && pending_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (pending_q.size() > 0)
                report($sformatf("%0d expected outputs never came", pending_q.size()));
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
